@@ hdl/mfep_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI file event parser package
// Shared types, codes and decode helpers of the track event parser.
// ----------------------------------------------------------------------------
package mfep_pkg;

  localparam int unsigned MaxVarlenDefault = 4;
  localparam int unsigned QueueDepth       = 2;
  localparam logic [7:0]  SysexStart       = 8'hF0;
  localparam logic [7:0]  SysexEscape      = 8'hF7;
  localparam logic [7:0]  MetaStatus       = 8'hFF;

  typedef enum logic [3:0] {
    PH_IDLE, PH_CH1, PH_CH2, PH_MTYPE, PH_LEN_META, PH_LEN_SYSEX, PH_PAY_META,
    PH_PAY_SYSEX
  } phase_e;

  typedef enum logic [4:0] {
    K_NOTE_OFF, K_NOTE_ON, K_POLY_AT, K_CTRL, K_PROGRAM, K_CHAN_AT, K_BEND,
    K_SEQ_NUM, K_TEXT, K_CHAN_PREFIX, K_TRACK_END, K_TEMPO, K_SMPTE, K_TIME_SIG,
    K_KEY_SIG, K_SEQ_SPECIFIC, K_UNKNOWN_META, K_SYSEX, K_ERROR
  } kind_e;

  typedef logic [4:0][7:0] bytes5_t;

  typedef struct packed {
    kind_e        kind;
    logic [3:0]   channel;
    logic [7:0]   meta_type;
    bytes5_t      args;
    logic [31:0]  wide_value;
    logic [27:0]  payload_length;
    logic         last;
  } result_t;

  function automatic logic is_fixed_meta(input logic [7:0] t);
    return t == 8'h00 || t == 8'h20 || t == 8'h2F || t == 8'h51 ||
           t == 8'h54 || t == 8'h58 || t == 8'h59;
  endfunction

  function automatic kind_e pass_kind(input logic [7:0] t);
    kind_e k;
    if (t >= 8'h01 && t <= 8'h07) k = K_TEXT;
    else if (t == 8'h7F) k = K_SEQ_SPECIFIC;
    else k = K_UNKNOWN_META;
    return k;
  endfunction

  function automatic result_t fixed_meta(input logic [7:0] t, input bytes5_t c,
                                         input logic [31:0] w, input logic [27:0] len);
    result_t r;
    r = '0;
    r.meta_type      = t;
    r.payload_length = len;
    r.last           = 1'b1;
    case (t)
      8'h00: begin r.kind = K_SEQ_NUM; r.wide_value = w; end
      8'h20: begin r.kind = K_CHAN_PREFIX; r.args[0] = c[0]; end
      8'h51: begin r.kind = K_TEMPO; r.wide_value = w; end
      8'h54: begin r.kind = K_SMPTE; r.args = c; end
      8'h58: begin
        r.kind = K_TIME_SIG;
        r.args[3:0] = c[3:0];
      end
      8'h59: begin
        r.kind = K_KEY_SIG;
        r.args[0] = c[0];
        r.args[1] = {7'd0, c[1] != 8'd0};
      end
      default: r.kind = K_TRACK_END;
    endcase
    return r;
  endfunction

  function automatic result_t channel_msg(input logic [7:0] rs, input logic [7:0] d1,
                                          input logic [7:0] d2);
    result_t r;
    r = '0;
    r.kind    = kind_e'({2'b00, rs[6:4]});
    r.channel = rs[3:0];
    r.last    = 1'b1;
    r.args[0] = d1;
    if (r.kind != K_PROGRAM && r.kind != K_CHAN_AT) r.args[1] = d2;
    if (r.kind == K_BEND) r.wide_value = {18'd0, d2[6:0], d1[6:0]};
    return r;
  endfunction

endpackage

@@ hdl/mfep_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI file event parser front end
// Classifies each byte, tracks the event phase and builds at most one result.
// ----------------------------------------------------------------------------
module mfep_parser #(
  parameter int unsigned MAX_VARLEN_BYTES = mfep_pkg::MaxVarlenDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [7:0]        data_byte_i,
  input  logic              event_start_i,
  output logic              res_valid_o,
  output mfep_pkg::result_t res_o
);
  import mfep_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  rs_q, rs_d, held_q, held_d;
  logic [27:0] len_q, len_d, rem_q, rem_d, len_n, rem_n, idx;
  logic [2:0]  cnt_q, cnt_d, cnt_n;
  bytes5_t     coll_q, coll_d;
  logic [31:0] wide_q, wide_d;
  logic        do_err, do_first;
  logic [7:0]  b;

  assign b = data_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      rs_q    <= '0;
      held_q  <= '0;
      len_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      coll_q  <= '0;
      wide_q  <= '0;
    end else if (valid_i) begin
      phase_q <= phase_d;
      rs_q    <= rs_d;
      held_q  <= held_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
      coll_q  <= coll_d;
      wide_q  <= wide_d;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    rs_d        = rs_q;
    held_d      = held_q;
    len_d       = len_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    coll_d      = coll_q;
    wide_d      = wide_q;
    res_o       = '0;
    res_valid_o = 1'b0;
    do_err      = 1'b0;
    do_first    = 1'b0;
    len_n       = {len_q[20:0], b[6:0]};
    cnt_n       = cnt_q + 3'd1;
    rem_n       = rem_q - 28'd1;
    idx         = len_q - rem_q;

    if (event_start_i) begin
      phase_d = PH_IDLE;
      if (!b[7]) begin
        if (rs_q == 8'd0) do_err = 1'b1;
        else do_first = 1'b1;
      end else if (b < SysexStart) begin
        rs_d    = b;
        phase_d = PH_CH1;
      end else begin
        rs_d = '0;
        if (b == MetaStatus) begin
          phase_d = PH_MTYPE;
        end else if (b == SysexStart || b == SysexEscape) begin
          held_d  = b;
          len_d   = '0;
          cnt_d   = '0;
          phase_d = PH_LEN_SYSEX;
        end else begin
          do_err = 1'b1;
        end
      end
    end else begin
      unique case (phase_q)
        PH_CH1: do_first = 1'b1;
        PH_CH2: begin
          res_o       = channel_msg(rs_q, coll_q[0], b);
          res_valid_o = 1'b1;
          phase_d     = PH_IDLE;
        end
        PH_MTYPE: begin
          held_d  = b;
          len_d   = '0;
          cnt_d   = '0;
          phase_d = PH_LEN_META;
        end
        PH_LEN_META, PH_LEN_SYSEX: begin
          len_d = len_n;
          cnt_d = cnt_n;
          if (!b[7]) begin
            coll_d  = '0;
            wide_d  = '0;
            rem_d   = len_n;
            phase_d = (phase_q == PH_LEN_SYSEX) ? PH_PAY_SYSEX : PH_PAY_META;
            if (len_n == 28'd0) begin
              phase_d     = PH_IDLE;
              res_valid_o = 1'b1;
              if (phase_q == PH_LEN_META && is_fixed_meta(held_q)) begin
                res_o = fixed_meta(held_q, '0, '0, len_n);
              end else begin
                res_o.kind      = (phase_q == PH_LEN_SYSEX) ? K_SYSEX : pass_kind(held_q);
                res_o.meta_type = held_q;
                res_o.last      = 1'b1;
              end
            end
          end else if (cnt_n >= 3'(MAX_VARLEN_BYTES)) begin
            do_err = 1'b1;
          end
        end
        PH_PAY_META, PH_PAY_SYSEX: begin
          if (idx < 28'd5) coll_d[idx[2:0]] = b;
          wide_d = {wide_q[23:0], b};
          rem_d  = rem_n;
          if (phase_q == PH_PAY_META && is_fixed_meta(held_q)) begin
            if (rem_n == 28'd0) begin
              res_o       = fixed_meta(held_q, coll_d, wide_d, len_q);
              res_valid_o = 1'b1;
              phase_d     = PH_IDLE;
            end
          end else begin
            res_o.kind           = (phase_q == PH_PAY_SYSEX) ? K_SYSEX : pass_kind(held_q);
            res_o.meta_type      = held_q;
            res_o.args[0]        = b;
            res_o.payload_length = len_q;
            res_o.last           = (rem_n == 28'd0);
            res_valid_o          = 1'b1;
            if (rem_n == 28'd0) phase_d = PH_IDLE;
          end
        end
        default: do_err = 1'b1;
      endcase
    end

    if (do_first) begin
      if (rs_q[7:4] == 4'hC || rs_q[7:4] == 4'hD) begin
        res_o       = channel_msg(rs_q, b, 8'd0);
        res_valid_o = 1'b1;
        phase_d     = PH_IDLE;
      end else begin
        coll_d[0] = b;
        phase_d   = PH_CH2;
      end
    end

    if (do_err) begin
      res_o         = '0;
      res_o.kind    = K_ERROR;
      res_o.args[0] = b;
      res_o.last    = 1'b1;
      res_valid_o   = 1'b1;
      rs_d          = '0;
      phase_d       = PH_IDLE;
    end
  end

endmodule

@@ hdl/mfep_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI file event parser result queue
// Small register queue that holds decoded results until they are popped.
// ----------------------------------------------------------------------------
module mfep_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  mfep_pkg::result_t wr_data_i,
  output logic              full_o,
  output logic              empty_o,
  input  logic              rd_i,
  output mfep_pkg::result_t rd_data_o
);
  import mfep_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  result_t         mem_q [QueueDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(QueueDepth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= (wp_q == PtrW'(QueueDepth - 1)) ? '0 : wp_q + 1'b1;
      if (do_rd) rp_q <= (rp_q == PtrW'(QueueDepth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + CntW'(do_wr) - CntW'(do_rd);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QueueDepth)) else $error("queue count overflow");
  a_wr_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_wr |=> !empty_o) else $error("written beat lost");
  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_rd && !do_wr && cnt_q == CntW'(1)) |=> empty_o) else $error("queue not drained");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || full_o) |-> wp_q == rp_q) else $error("pointer mismatch");

endmodule

@@ hdl/midi_file_event_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI file event parser
// Decodes standard MIDI file track events one byte per beat into results.
// ----------------------------------------------------------------------------
// A result is queued at the clock edge that accepts the byte completing it.
// Takes one byte per cycle while the result queue is not full.
// A two-entry result queue keeps input flowing while a result waits to be popped.
// Reset is asynchronous and active low; the parser returns to idle with no
// running status and the result queue empties.
module midi_file_event_parser #(
  parameter int unsigned MAX_VARLEN_BYTES = mfep_pkg::MaxVarlenDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        event_start_i,
  output logic        empty,
  input  logic        pop,
  output logic [4:0]  kind_o,
  output logic [3:0]  channel_o,
  output logic [7:0]  meta_type_o,
  output logic [7:0]  arg0_o,
  output logic [7:0]  arg1_o,
  output logic [7:0]  arg2_o,
  output logic [7:0]  arg3_o,
  output logic [7:0]  arg4_o,
  output logic [31:0] wide_value_o,
  output logic [27:0] payload_length_o,
  output logic        last_o
);
  import mfep_pkg::*;

  logic    acc, res_valid;
  result_t res, head;

  assign acc = push && !full;

  mfep_parser #(.MAX_VARLEN_BYTES(MAX_VARLEN_BYTES)) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (acc),
    .data_byte_i   (data_byte_i),
    .event_start_i (event_start_i),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  mfep_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (acc && res_valid),
    .wr_data_i (res),
    .full_o    (full),
    .empty_o   (empty),
    .rd_i      (pop),
    .rd_data_o (head)
  );

  assign kind_o           = head.kind;
  assign channel_o        = head.channel;
  assign meta_type_o      = head.meta_type;
  assign arg0_o           = head.args[0];
  assign arg1_o           = head.args[1];
  assign arg2_o           = head.args[2];
  assign arg3_o           = head.args[3];
  assign arg4_o           = head.args[4];
  assign wide_value_o     = head.wide_value;
  assign payload_length_o = head.payload_length;
  assign last_o           = head.last;

endmodule

@@ tb/mfep_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI file event parser checker
// Watches the byte and result channels, predicts each result from the bytes
// accepted so far, and compares every result beat field by field in order.
// ----------------------------------------------------------------------------
module mfep_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [7:0]  data_byte_i,
  input  logic        event_start_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [4:0]  kind_i,
  input  logic [3:0]  channel_i,
  input  logic [7:0]  meta_type_i,
  input  logic [7:0]  arg0_i,
  input  logic [7:0]  arg1_i,
  input  logic [7:0]  arg2_i,
  input  logic [7:0]  arg3_i,
  input  logic [7:0]  arg4_i,
  input  logic [31:0] wide_value_i,
  input  logic [27:0] payload_length_i,
  input  logic        last_i,
  output int          errors_o,
  output int          pending_o,
  output int          results_o
);
  import mfep_pkg::*;

  localparam int unsigned VarlenLimit = MaxVarlenDefault;

  typedef struct packed {
    logic [4:0]  kind;
    logic [3:0]  channel;
    logic [7:0]  meta_type;
    logic [7:0]  a0, a1, a2, a3, a4;
    logic [31:0] wide;
    logic [27:0] plen;
    logic        last;
  } event_result_t;

  event_result_t expected_results[$];

  logic [7:0]  run_status;
  phase_e      phase;
  logic [7:0]  meta_kind;
  logic [27:0] len_acc;
  logic [2:0]  len_count;
  logic [27:0] remaining;
  logic [7:0]  stash [5];
  logic [31:0] wide_acc;

  function automatic event_result_t blank(input logic [4:0] k, input logic [3:0] ch,
                                          input logic [7:0] mt);
    event_result_t r;
    r = '0;
    r.kind = k;
    r.channel = ch;
    r.meta_type = mt;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic logic fixed_type(input logic [7:0] t);
    return t == 8'h00 || t == 8'h20 || t == 8'h2F || t == 8'h51 ||
           t == 8'h54 || t == 8'h58 || t == 8'h59;
  endfunction

  function automatic logic [4:0] payload_kind(input logic [7:0] t);
    if (t >= 8'h01 && t <= 8'h07) return K_TEXT;
    if (t == 8'h7F) return K_SEQ_SPECIFIC;
    return K_UNKNOWN_META;
  endfunction

  task automatic flag_error(input logic [7:0] b);
    event_result_t r;
    r = blank(K_ERROR, 4'd0, 8'd0);
    r.a0 = b;
    expected_results.push_back(r);
    run_status = 8'd0;
    phase = PH_IDLE;
  endtask

  task automatic finish_fixed();
    event_result_t r;
    logic [4:0] k;
    case (meta_kind)
      8'h00: k = K_SEQ_NUM;
      8'h20: k = K_CHAN_PREFIX;
      8'h51: k = K_TEMPO;
      8'h54: k = K_SMPTE;
      8'h58: k = K_TIME_SIG;
      8'h59: k = K_KEY_SIG;
      default: k = K_TRACK_END;
    endcase
    r = blank(k, 4'd0, meta_kind);
    r.plen = len_acc;
    case (k)
      K_SEQ_NUM, K_TEMPO: r.wide = wide_acc;
      K_CHAN_PREFIX: r.a0 = stash[0];
      K_SMPTE: begin
        r.a0 = stash[0]; r.a1 = stash[1]; r.a2 = stash[2]; r.a3 = stash[3]; r.a4 = stash[4];
      end
      K_TIME_SIG: begin
        r.a0 = stash[0]; r.a1 = stash[1]; r.a2 = stash[2]; r.a3 = stash[3];
      end
      K_KEY_SIG: begin
        r.a0 = stash[0]; r.a1 = (stash[1] != 8'd0) ? 8'd1 : 8'd0;
      end
      default: ;
    endcase
    expected_results.push_back(r);
    phase = PH_IDLE;
  endtask

  task automatic finish_channel(input logic [7:0] d1, input logic [7:0] d2);
    event_result_t r;
    logic [4:0] k;
    k = {2'b00, run_status[6:4]};
    r = blank(k, run_status[3:0], 8'd0);
    r.a0 = d1;
    if (k != K_PROGRAM && k != K_CHAN_AT) r.a1 = d2;
    if (k == K_BEND) r.wide = {18'd0, d2[6:0], d1[6:0]};
    expected_results.push_back(r);
    phase = PH_IDLE;
  endtask

  task automatic first_data(input logic [7:0] b);
    if (run_status[7:4] == 4'hC || run_status[7:4] == 4'hD) begin
      finish_channel(b, 8'd0);
    end else begin
      stash[0] = b;
      phase = PH_CH2;
    end
  endtask

  task automatic length_complete();
    logic sx;
    sx = (phase == PH_LEN_SYSEX);
    for (int i = 0; i < 5; i++) stash[i] = 8'd0;
    wide_acc = 32'd0;
    remaining = len_acc;
    phase = sx ? PH_PAY_SYSEX : PH_PAY_META;
    if (len_acc == 28'd0) begin
      phase = PH_IDLE;
      if (!sx && fixed_type(meta_kind)) finish_fixed();
      else expected_results.push_back(blank(sx ? 5'(K_SYSEX) : payload_kind(meta_kind),
                                            4'd0, meta_kind));
    end
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic st);
    event_result_t r;
    logic [27:0] idx;
    logic sx;
    if (st) begin
      phase = PH_IDLE;
      if (b < 8'h80) begin
        if (run_status == 8'd0) flag_error(b);
        else first_data(b);
      end else if (b < 8'hF0) begin
        run_status = b;
        phase = PH_CH1;
      end else begin
        run_status = 8'd0;
        if (b == MetaStatus) phase = PH_MTYPE;
        else if (b == SysexStart || b == SysexEscape) begin
          meta_kind = b;
          len_acc = '0;
          len_count = '0;
          phase = PH_LEN_SYSEX;
        end else flag_error(b);
      end
      return;
    end
    case (phase)
      PH_CH1: first_data(b);
      PH_CH2: finish_channel(stash[0], b);
      PH_MTYPE: begin
        meta_kind = b;
        len_acc = '0;
        len_count = '0;
        phase = PH_LEN_META;
      end
      PH_LEN_META, PH_LEN_SYSEX: begin
        len_acc = {len_acc[20:0], b[6:0]};
        len_count = len_count + 3'd1;
        if (!b[7]) length_complete();
        else if (len_count >= VarlenLimit) flag_error(b);
      end
      PH_PAY_META, PH_PAY_SYSEX: begin
        idx = len_acc - remaining;
        sx = (phase == PH_PAY_SYSEX);
        if (idx < 5) stash[idx[2:0]] = b;
        wide_acc = {wide_acc[23:0], b};
        remaining = remaining - 28'd1;
        if (!sx && fixed_type(meta_kind)) begin
          if (remaining == 0) finish_fixed();
        end else begin
          r = blank(sx ? 5'(K_SYSEX) : payload_kind(meta_kind), 4'd0, meta_kind);
          r.a0 = b;
          r.plen = len_acc;
          r.last = (remaining == 0);
          expected_results.push_back(r);
          if (remaining == 0) phase = PH_IDLE;
        end
      end
      default: flag_error(b);
    endcase
  endtask

  event_result_t seen, want;

  assign seen = '{kind_i, channel_i, meta_type_i, arg0_i, arg1_i, arg2_i, arg3_i, arg4_i,
                  wide_value_i, payload_length_i, last_i};
  assign pending_o = expected_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_status = 8'd0;
      phase = PH_IDLE;
      meta_kind = 8'd0;
      len_acc = '0;
      len_count = '0;
      remaining = '0;
      wide_acc = '0;
      for (int i = 0; i < 5; i++) stash[i] = 8'd0;
      errors_o <= 0;
      results_o <= 0;
    end else begin
      if (pop_i && !empty_i) begin
        results_o <= results_o + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none actual %p", $time, seen);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_results.pop_front();
          if (want != seen) begin
            $display("%0t: result mismatch: expected %p actual %p", $time, want, seen);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (push_i && !full_i) predict_byte(data_byte_i, event_start_i);
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI file event parser testbench
// Drives well-formed track events with random content, broken events and
// noise bytes under varied idling, and lets the checker judge every result.
// ----------------------------------------------------------------------------
module tb_top;
  import mfep_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte_i = 8'd0;
  logic        event_start_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [4:0]  kind_o;
  logic [3:0]  channel_o;
  logic [7:0]  meta_type_o, arg0_o, arg1_o, arg2_o, arg3_o, arg4_o;
  logic [31:0] wide_value_o;
  logic [27:0] payload_length_o;
  logic        last_o;
  int          errors, pending, results;
  int          send_idle = 0;
  int          recv_stall = 0;
  bit          hold_off = 1'b0;
  int          bytes_sent = 0;
  longint      cycles = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  midi_file_event_parser dut (.*);

  mfep_checker checker_i (
    .clk_i, .rst_ni, .push_i(push), .full_i(full), .data_byte_i, .event_start_i,
    .empty_i(empty), .pop_i(pop), .kind_i(kind_o), .channel_i(channel_o),
    .meta_type_i(meta_type_o), .arg0_i(arg0_o), .arg1_i(arg1_o), .arg2_i(arg2_o),
    .arg3_i(arg3_o), .arg4_i(arg4_o), .wide_value_i(wide_value_o),
    .payload_length_i(payload_length_o), .last_i(last_o), .errors_o(errors),
    .pending_o(pending), .results_o(results)
  );

  always @(negedge clk_i) begin
    pop <= !hold_off && ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic st);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    data_byte_i <= b;
    event_start_i <= st;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_length(input int unsigned n, input int unsigned groups);
    for (int i = int'(groups) - 1; i >= 0; i--)
      send_byte({i != 0, 7'(n >> (7 * i))}, 1'b0);
  endtask

  task automatic send_meta(input logic [7:0] t, input int unsigned n);
    send_byte(MetaStatus, 1'b1);
    send_byte(t, 1'b0);
    send_length(n, (n < 128) ? 1 : 2);
    for (int i = 0; i < n; i++) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic send_random_event();
    logic [7:0] fixed_types [7] = '{8'h00, 8'h20, 8'h2F, 8'h51, 8'h54, 8'h58, 8'h59};
    logic [7:0] status;
    int unsigned pick, n, cut;
    pick = $urandom_range(99);
    if (pick < 45) begin
      status = {1'b1, 3'($urandom_range(6)), 4'($urandom)};
      if ($urandom_range(3) != 0) send_byte(status, 1'b1);
      else send_byte({1'b0, 7'($urandom)}, 1'b1);
      send_byte(8'($urandom), 1'b0);
      if (status[6:4] != 3'd4 && status[6:4] != 3'd5) send_byte(8'($urandom), 1'b0);
    end else if (pick < 65) begin
      send_meta(fixed_types[$urandom_range(6)], $urandom_range(6));
    end else if (pick < 78) begin
      send_meta(($urandom_range(1) != 0) ? 8'($urandom_range(7)) : 8'($urandom),
                $urandom_range(5));
    end else if (pick < 86) begin
      n = $urandom_range(4);
      send_byte(($urandom_range(1) != 0) ? SysexStart : SysexEscape, 1'b1);
      send_length(n, 1);
      for (int i = 0; i < n; i++) send_byte(8'($urandom), 1'b0);
    end else if (pick < 93) begin
      send_byte(MetaStatus, 1'b1);
      send_byte(8'($urandom), 1'b0);
      cut = $urandom_range(1, 6);
      for (int i = 0; i < cut; i++) send_byte(8'($urandom) | 8'h80, 1'b0);
    end else begin
      send_byte(8'($urandom), $urandom_range(1));
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_byte(8'h45, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h90, 1'b1); send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b1); send_byte(8'h80, 1'b0);
    send_byte(8'hEF, 1'b1); send_byte(8'hFF, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hC3, 1'b1); send_byte(8'h7F, 1'b0);
    send_byte(8'hD0, 1'b1); send_byte(8'h00, 1'b0);
    send_byte(8'hA1, 1'b1); send_byte(8'h01, 1'b0); send_byte(8'h02, 1'b0);
    send_byte(8'hB2, 1'b1); send_byte(8'h03, 1'b0);
    send_byte(8'h8F, 1'b1); send_byte(8'h3C, 1'b0); send_byte(8'h40, 1'b0);
    send_byte(8'hF1, 1'b1);
    send_byte(8'hFE, 1'b1);
    send_byte(8'h10, 1'b1);
    send_meta(8'h51, 3); send_meta(8'h54, 5); send_meta(8'h58, 4); send_meta(8'h59, 2);
    send_meta(8'h00, 6); send_meta(8'h20, 0); send_meta(8'h2F, 0); send_meta(8'h01, 0);
    send_meta(8'h7F, 2); send_meta(8'h33, 1);
    send_byte(SysexStart, 1'b1); send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(SysexEscape, 1'b1); send_byte(8'h00, 1'b0);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1 || ph == 3) ? ((ph == 3) ? 38 : 49) : 0;
      recv_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 38 : 49) : 0;
      while (bytes_sent < 300 * (ph + 1) + 100) send_random_event();
      if (ph == 1) begin
        hold_off = 1'b1;
        fork
          begin
            repeat (200) @(negedge clk_i);
            hold_off = 1'b0;
          end
          begin
            repeat (30) send_random_event();
            push <= 1'b0;
          end
        join
        hold_off = 1'b0;
      end
      drain();
    end
    send_idle = 0;
    recv_stall = 0;
    while (bytes_sent < 1350) send_random_event();
    drain();
    $display("Sent %0d bytes of channel, meta, sysex and malformed events;", bytes_sent);
    $display("checked %0d results under several idling mixes.", results);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
